// File: rtl/core/xorshift32_bounded_random_unit_macros.svh
// Assertion macros for the bounded random unit.
`ifndef XORSHIFT32_BOUNDED_RANDOM_UNIT_MACROS_SVH
`define XORSHIFT32_BOUNDED_RANDOM_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define XBR_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define XBR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define XBR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define XBR_ASSERT_ALWAYS(lbl, clk, rst, expr)

`define XBR_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define XBR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/xbr_pkg.sv
// Shared types, constants and the generator step for the bounded random unit.
package xbr_pkg;

   localparam int WORD_W   = 32;
   localparam int DRAW_W   = 8;
   localparam int OPCODE_W = 2;

   localparam logic [WORD_W-1:0] ZERO_FILL = 32'h6D2B_79F5;

   localparam logic [OPCODE_W-1:0] OP_SEED    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RAW     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_BOUNDED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_THRESH,
      ST_DRAW,
      ST_REDUCE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [WORD_W-1:0] xorshift_step(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] s;
      s = (word == '0) ? ZERO_FILL : word;
      s = s ^ (s << 13);
      s = s ^ (s >> 17);
      s = s ^ (s << 5);
      return s;
   endfunction

endpackage

// File: rtl/core/xbr_if.sv
// Request and response channel interfaces for the bounded random unit.
interface xbr_req_if import xbr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [WORD_W-1:0]   operand;

   modport source (output valid, output opcode, output operand, input ready);
   modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface xbr_rsp_if import xbr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] value;
   logic [DRAW_W-1:0] draw_count;

   modport source (output valid, output value, output draw_count, input ready);
   modport sink   (input valid, input value, input draw_count, output ready);
endinterface

// File: rtl/core/xbr_div.sv
// Radix-2 restoring remainder unit, one quotient bit per cycle.
module xbr_div import xbr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(WORD_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   dvd_ff, dvd_in;
   logic [WORD_W-1:0]   dvs_ff, dvs_in;
   logic [WORD_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, dvd_ff[WORD_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = WORD_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[WORD_W-1:0];
         end
         dvd_in  = {dvd_ff[WORD_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// File: rtl/core/xorshift32_bounded_random_unit.sv
// Top level of the xorshift32 bounded random unit.
//
// Requests arrive on req_bus (opcode, operand), results leave on rsp_bus
// (value, draw_count), one result per request, valid/ready on both sides.
// Seed loads the generator word and answers zero. Raw steps the generator
// once and answers the new word with a draw count of one. Bounded computes
// the rejection threshold (2^32 mod bound), draws until a word reaches it,
// and answers word mod bound with the number of draws, modulo 256. A bound
// of zero or one, and the unused opcode, answer zero without a draw.
// Both remainders run on the shared divider at one bit per cycle. req_bus.ready
// is high only while the sequencer is idle, so a new request is taken only
// after the previous one has left the sequencer.
// A result register sits at the output: a new request is taken while a
// result waits; a stalled receiver holds the finished item in the sequencer.
// Reset clears the generator word to zero and empties the result register.
`include "xorshift32_bounded_random_unit_macros.svh"

module xorshift32_bounded_random_unit import xbr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   xbr_req_if.sink  req_bus,
   xbr_rsp_if.source rsp_bus
);

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] bound_ff, bound_in;
   logic [WORD_W-1:0] thresh_ff, thresh_in;
   logic [WORD_W-1:0] result_ff, result_in;
   logic [DRAW_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [DRAW_W-1:0] rsp_count_ff, rsp_count_in;
   logic [WORD_W-1:0] step_word;
   logic              req_fire;
   logic              out_load;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign step_word = xorshift_step(word_ff);
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   xbr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.opcode == OP_BOUNDED && req_bus.operand > WORD_W'(1)) begin
                  state_in = ST_THRESH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_THRESH: begin
            if (div_rsp.done) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (step_word >= thresh_ff) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      word_in          = word_ff;
      bound_in         = bound_ff;
      thresh_in        = thresh_ff;
      result_in        = result_ff;
      count_in         = count_ff;
      div_req.start    = 1'b0;
      div_req.dividend = step_word;
      div_req.divisor  = bound_ff;
      req_bus.ready    = (state_ff == ST_IDLE);
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in     = rsp_value_ff;
      rsp_count_in     = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               result_in = '0;
               count_in  = '0;
               case (req_bus.opcode)
                  OP_SEED: begin
                     word_in = req_bus.operand;
                  end
                  OP_RAW: begin
                     word_in   = step_word;
                     result_in = step_word;
                     count_in  = DRAW_W'(1);
                  end
                  OP_BOUNDED: begin
                     bound_in = req_bus.operand;
                     if (req_bus.operand > WORD_W'(1)) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = '0 - req_bus.operand;
                        div_req.divisor  = req_bus.operand;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_THRESH: begin
            if (div_rsp.done) begin
               thresh_in = div_rsp.remainder;
            end
         end
         ST_DRAW: begin
            word_in  = step_word;
            count_in = count_ff + 1'b1;
            if (step_word >= thresh_ff) begin
               div_req.start = 1'b1;
            end
         end
         ST_REDUCE: begin
            if (div_rsp.done) begin
               result_in = div_rsp.remainder;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               rsp_count_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bound_ff     <= bound_in;
      thresh_ff    <= thresh_in;
      result_ff    <= result_in;
      count_ff     <= count_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.value      = rsp_value_ff;
   assign rsp_bus.draw_count = rsp_count_ff;

   `XBR_ASSERT_NEXT(a_word_hold, clock, reset, (state_ff == ST_THRESH || state_ff == ST_REDUCE || state_ff == ST_DONE), $stable(word_ff))
   `XBR_ASSERT_IMPLY(a_bounded_below, clock, reset, (state_ff == ST_REDUCE && div_rsp.done), (div_rsp.remainder < bound_ff))
   `XBR_ASSERT_ALWAYS(a_div_owner, clock, reset, (!div_rsp.done || state_ff == ST_THRESH || state_ff == ST_REDUCE))
   `XBR_ASSERT_NEXT(a_done_loads, clock, reset, (state_ff == ST_DONE && !rsp_valid_ff), (rsp_valid_ff && state_ff == ST_IDLE))

endmodule

// File: tb/sv/xorshift32_bounded_random_unit_checker.sv
`timescale 1ns / 100ps
// Result checker for the bounded random unit: predicts every result and compares it.
module xorshift32_bounded_random_unit_checker import xbr_pkg::*; (
   input  logic clock,
   input  logic reset,
   xbr_req_if   req_mon,
   xbr_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   outstanding
);

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [DRAW_W-1:0] draw_count;
   } draw_result_type;

   logic [WORD_W-1:0] gen_word;
   draw_result_type   expected_draws_q[$];

   function automatic logic [WORD_W-1:0] advance_word();
      logic [WORD_W-1:0] w;
      w = (gen_word == '0) ? ZERO_FILL : gen_word;
      w = w ^ {w[WORD_W-14:0], 13'b0};
      w = w ^ {17'b0, w[WORD_W-1:17]};
      w = w ^ {w[WORD_W-6:0], 5'b0};
      gen_word = w;
      return w;
   endfunction

   function automatic draw_result_type apply_request(input logic [OPCODE_W-1:0] op,
                                                     input logic [WORD_W-1:0]   arg);
      draw_result_type   r;
      logic [WORD_W-1:0] floor_word;
      logic [WORD_W-1:0] w;
      r = '0;
      case (op)
         OP_SEED: gen_word = arg;
         OP_RAW: begin
            r.value      = advance_word();
            r.draw_count = 8'd1;
         end
         OP_BOUNDED: begin
            if (arg > 32'd1) begin
               floor_word = (~arg + 32'd1) % arg;
               do begin
                  w            = advance_word();
                  r.draw_count = r.draw_count + 8'd1;
               end while (w < floor_word);
               r.value = w % arg;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      draw_result_type want;
      if (reset) begin
         gen_word = '0;
         expected_draws_q.delete();
         mismatch_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_draws_q.push_back(apply_request(req_mon.opcode, req_mon.operand));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_draws_q.size() == 0) begin
               $error("unexpected item: value %h draw_count %0d",
                      rsp_mon.value, rsp_mon.draw_count);
               mismatch_count++;
            end else begin
               want = expected_draws_q.pop_front();
               if (rsp_mon.value !== want.value) begin
                  $error("value: expected %h, actual %h", want.value, rsp_mon.value);
                  mismatch_count++;
               end
               if (rsp_mon.draw_count !== want.draw_count) begin
                  $error("draw_count: expected %0d, actual %0d",
                         want.draw_count, rsp_mon.draw_count);
                  mismatch_count++;
               end
            end
         end
      end
      outstanding <= expected_draws_q.size();
   end

endmodule

// File: tb/sv/xorshift32_bounded_random_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the bounded random unit: clock, reset, stimulus and verdict.
module xorshift32_bounded_random_unit_tb;
   import xbr_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b0;
   int   mismatch_count;
   int   outstanding;
   int   cycle_count = 0;

   xbr_req_if req_bus ();
   xbr_rsp_if rsp_bus ();

   xorshift32_bounded_random_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   xorshift32_bounded_random_unit_checker draw_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 10);
   end

   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] arg);
      while (!steady && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.operand <= arg;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      logic [OPCODE_W-1:0] op;
      logic [WORD_W-1:0]   arg;
      int                  roll;
      req_bus.valid   <= 1'b0;
      req_bus.opcode  <= OP_SEED;
      req_bus.operand <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero state right after reset, then zero and all-ones seeds, bound corner cases and the unused opcode
      send_item(OP_RAW, 32'h0000_0000);
      send_item(OP_SEED, 32'h0000_0000);
      send_item(OP_RAW, 32'hFFFF_FFFF);
      send_item(OP_SEED, 32'hFFFF_FFFF);
      send_item(OP_RAW, 32'h0000_0000);
      send_item(OP_BOUNDED, 32'h0000_0000);
      send_item(OP_BOUNDED, 32'h0000_0001);
      send_item(OP_BOUNDED, 32'h0000_0002);
      send_item(OP_BOUNDED, 32'h0000_0003);
      send_item(OP_BOUNDED, 32'hFFFF_FFFF);
      send_item(OP_BOUNDED, 32'h8000_0000);
      send_item(OP_BOUNDED, 32'h8000_0001);
      send_item(OP_BOUNDED, 32'hAAAA_AAAB);
      send_item(OP_UNUSED, 32'hFFFF_FFFF);
      send_item(OP_UNUSED, 32'h0000_0000);
      send_item(OP_SEED, 32'h0000_0000);
      send_item(OP_BOUNDED, 32'h0000_000A);
      send_item(OP_SEED, 32'h0000_0001);
      send_item(OP_BOUNDED, 32'h0000_0005);
      send_item(OP_RAW, 32'h5555_5555);
      send_item(OP_SEED, 32'h5555_5555);
      send_item(OP_BOUNDED, 32'h0000_0006);
      send_item(OP_SEED, 32'h0000_0000);
      send_item(OP_BOUNDED, 32'h0000_0001);
      send_item(OP_RAW, 32'hAAAA_AAAA);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady <= (i >= 500 && i < 700);
         if (i == 300 || i == 900)
            drain();
         roll = $urandom_range(99);
         arg  = $urandom();
         if (roll < 10) begin
            op = OP_SEED;
            if ($urandom_range(9) == 0)
               arg = '0;
         end else if (roll < 40) begin
            op = OP_RAW;
         end else if (roll < 95) begin
            op = OP_BOUNDED;
            case ($urandom_range(5))
               0: arg = $urandom_range(1);
               1: arg = $urandom_range(16, 2);
               2: arg = 32'd1 << $urandom_range(31, 1);
               3: arg = $urandom();
               4: arg = 32'h8000_0000 + $urandom_range(255);
               default: arg = 32'hFFFF_FFFF - $urandom_range(255);
            endcase
         end else begin
            op = OP_UNUSED;
         end
         send_item(op, arg);
      end

      steady <= 1'b0;
      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/xbr_pkg.sv
rtl/core/xbr_if.sv
rtl/core/xbr_div.sv
rtl/core/xorshift32_bounded_random_unit.sv
tb/sv/xorshift32_bounded_random_unit_checker.sv
tb/sv/xorshift32_bounded_random_unit_tb.sv
